>>> rtl/clqm_pkg.sv
// Shared types and constants for the circular linked queue manager.
package clqm_pkg;

    localparam int POOL_ENTRIES = 64;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;

    // Pool size in the width of the entry count.
    localparam logic [CNT_W-1:0] POOL_LIMIT = CNT_W'(POOL_ENTRIES);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SIZE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_LINKED     = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_NOT_MEMBER = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPEND_LINK
    } state_t;

endpackage

>>> rtl/circular_linked_queue_manager_top.sv
// Circular doubly linked queue over a pool of entries, with link memories and sequencer.
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  in      | in_valid, in_ready, kind, entry_index                | in
//  out     | out_valid, out_ready, status, removed_entry,         | out
//          | entry_count, head_entry, queue_empty                 |
//
// An item passes through accept, then evaluate, and an append to a non-empty queue
// adds a link step: the next and prev link memories each take one write per cycle,
// and that append rewrites two links in each. Link reads are issued at accept time.
// Reset empties the queue at once: the linked flags, count and head are cleared;
// link memories are left as they are. A held result stalls the evaluate and link
// steps; the next item is accepted while the result register still waits.
module circular_linked_queue_manager_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [5:0] entry_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [5:0] removed_entry,
    output logic [6:0] entry_count,
    output logic [5:0] head_entry,
    output logic       queue_empty
);

    clqm_pkg::state_t state_reg, state_next;

    logic [1:0]       kind_reg, kind_next;
    clqm_pkg::idx_t   idx_reg, idx_next;
    clqm_pkg::idx_t   head_reg, head_next;
    logic             empty_reg, empty_next;
    clqm_pkg::cnt_t   count_reg, count_next;
    logic [clqm_pkg::POOL_ENTRIES-1:0] linked_reg, linked_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    clqm_pkg::idx_t   removed_reg, removed_next;
    clqm_pkg::cnt_t   count_out_reg, count_out_next;
    clqm_pkg::idx_t   head_out_reg, head_out_next;
    logic             empty_out_reg, empty_out_next;

    // Link memories
    clqm_pkg::idx_t   next_mem [clqm_pkg::POOL_ENTRIES];
    clqm_pkg::idx_t   prev_mem [clqm_pkg::POOL_ENTRIES];
    clqm_pkg::idx_t   nrd_reg, prd_reg;
    clqm_pkg::idx_t   n_raddr, p_raddr;
    logic             n_we, p_we;
    clqm_pkg::idx_t   n_waddr, p_waddr, n_wdata, p_wdata;

    logic             accept;
    logic             out_free;
    logic             in_pool;
    clqm_pkg::cnt_t   cnt_dec;

    assign in_ready = (state_reg == clqm_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_pool  = {1'b0, idx_reg} < clqm_pkg::POOL_LIMIT;
    assign cnt_dec  = (count_reg != '0) ? count_reg - 1'b1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clqm_pkg::S_IDLE;
            head_reg      <= '0;
            empty_reg     <= 1'b1;
            count_reg     <= '0;
            linked_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            count_reg     <= count_next;
            linked_reg    <= linked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        idx_reg       <= idx_next;
        status_reg    <= status_next;
        removed_reg   <= removed_next;
        count_out_reg <= count_out_next;
        head_out_reg  <= head_out_next;
        empty_out_reg <= empty_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            next_mem[n_waddr] <= n_wdata;
        end
        if (p_we)
        begin
            prev_mem[p_waddr] <= p_wdata;
        end
        nrd_reg <= next_mem[n_raddr];
        prd_reg <= prev_mem[p_raddr];
    end

    always_comb
    begin
        logic finish;
        logic busy;

        state_next     = state_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        count_next     = count_reg;
        linked_next    = linked_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        count_out_next = count_out_reg;
        head_out_next  = head_out_reg;
        empty_out_next = empty_out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        // Append reads the tail link at the head; remove reads both links of the entry.
        // Once the item is held, keep reading its own links so a stall does not lose them.
        if (state_reg == clqm_pkg::S_IDLE)
        begin
            n_raddr = entry_index;
            p_raddr = (kind == clqm_pkg::KIND_APPEND) ? head_reg : entry_index;
        end
        else
        begin
            n_raddr = idx_reg;
            p_raddr = (kind_reg == clqm_pkg::KIND_APPEND) ? head_reg : idx_reg;
        end
        n_we    = 1'b0;
        p_we    = 1'b0;
        n_waddr = idx_reg;
        p_waddr = idx_reg;
        n_wdata = idx_reg;
        p_wdata = idx_reg;

        finish = 1'b0;
        busy   = 1'b0;
        status_next = status_reg;

        case (state_reg)
            clqm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind;
                    idx_next   = entry_index;
                    state_next = clqm_pkg::S_EVAL;
                end
            end

            clqm_pkg::S_EVAL:
            begin
                if (out_free)
                begin
                    finish       = 1'b1;
                    status_next  = clqm_pkg::ST_OK;
                    removed_next = '0;
                    case (kind_reg)
                        clqm_pkg::KIND_APPEND:
                        begin
                            if (!in_pool)
                            begin
                                status_next = clqm_pkg::ST_NOT_MEMBER;
                            end
                            else if (linked_reg[idx_reg])
                            begin
                                status_next = clqm_pkg::ST_LINKED;
                            end
                            else if (empty_reg)
                            begin
                                // Sole entry links to itself both ways
                                n_we                 = 1'b1;
                                p_we                 = 1'b1;
                                head_next            = idx_reg;
                                empty_next           = 1'b0;
                                linked_next[idx_reg] = 1'b1;
                                count_next           = clqm_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                // Hook the entry behind the tail; head side follows
                                n_we    = 1'b1;
                                n_waddr = prd_reg;
                                n_wdata = idx_reg;
                                p_we    = 1'b1;
                                p_waddr = idx_reg;
                                p_wdata = prd_reg;
                                busy    = 1'b1;
                            end
                        end

                        clqm_pkg::KIND_REMOVE:
                        begin
                            if (empty_reg)
                            begin
                                status_next = clqm_pkg::ST_EMPTY;
                            end
                            else if (!in_pool || !linked_reg[idx_reg])
                            begin
                                status_next = clqm_pkg::ST_NOT_MEMBER;
                            end
                            else
                            begin
                                // Bridge the neighbors over the entry
                                p_we                 = 1'b1;
                                p_waddr              = nrd_reg;
                                p_wdata              = prd_reg;
                                n_we                 = 1'b1;
                                n_waddr              = prd_reg;
                                n_wdata              = nrd_reg;
                                linked_next[idx_reg] = 1'b0;
                                removed_next         = idx_reg;
                                if (nrd_reg == idx_reg || cnt_dec == '0)
                                begin
                                    empty_next = 1'b1;
                                    head_next  = '0;
                                    count_next = '0;
                                end
                                else
                                begin
                                    count_next = cnt_dec;
                                    if (head_reg == idx_reg)
                                    begin
                                        head_next = nrd_reg;
                                    end
                                end
                            end
                        end

                        default:
                        begin
                            status_next = clqm_pkg::ST_OK;
                        end
                    endcase

                    if (busy)
                    begin
                        finish     = 1'b0;
                        state_next = clqm_pkg::S_APPEND_LINK;
                    end
                end
            end

            clqm_pkg::S_APPEND_LINK:
            begin
                if (out_free)
                begin
                    // Close the ring back to the head
                    n_we                 = 1'b1;
                    n_waddr              = idx_reg;
                    n_wdata              = head_reg;
                    p_we                 = 1'b1;
                    p_waddr              = head_reg;
                    p_wdata              = idx_reg;
                    linked_next[idx_reg] = 1'b1;
                    count_next           = count_reg + 1'b1;
                    status_next          = clqm_pkg::ST_OK;
                    removed_next         = '0;
                    finish               = 1'b1;
                end
            end

            default:
            begin
                state_next = clqm_pkg::S_IDLE;
            end
        endcase

        if (finish)
        begin
            out_valid_next = 1'b1;
            count_out_next = count_next;
            head_out_next  = empty_next ? '0 : head_next;
            empty_out_next = empty_next;
            state_next     = clqm_pkg::S_IDLE;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_entry = removed_reg;
    assign entry_count   = count_out_reg;
    assign head_entry    = head_out_reg;
    assign queue_empty   = empty_out_reg;

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= clqm_pkg::POOL_LIMIT)
        else $error("entry count beyond pool");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg == (count_reg == '0))
        else $error("empty flag disagrees with count");

    a_flags_count: assert property (@(posedge clk) disable iff (!rst_n)
        clqm_pkg::CNT_W'($countones(linked_reg)) == count_reg)
        else $error("linked flags disagree with count");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> head_reg == '0)
        else $error("head not cleared on empty queue");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == clqm_pkg::S_EVAL)
        else $error("accepted item not evaluated");

endmodule

>>> sim/circular_linked_queue_manager_top_test.sv
// Self-checking testbench for the circular linked queue manager top level.
module circular_linked_queue_manager_top_test;

    localparam logic [1:0] KIND_SPARE   = 2'd3;    // unused code, answered as a size query
    localparam int         DIR_ROWS     = 23;
    localparam int         RANDOM_ITEMS = 1830;
    localparam int         LONG_HOLD    = 400;
    localparam int         SETTLE       = 20;
    localparam int         CYCLE_LIMIT  = 300000;

    typedef struct {
        clqm_pkg::status_t st;
        clqm_pkg::idx_t    rem;
        clqm_pkg::cnt_t    cnt;
        clqm_pkg::idx_t    head;
        logic              empty;
    } reply_t;

    typedef struct {
        logic [1:0]        op;
        clqm_pkg::idx_t    ix;
        bit                typed;
        clqm_pkg::status_t st;
        clqm_pkg::idx_t    rem;
        clqm_pkg::cnt_t    cnt;
        clqm_pkg::idx_t    head;
        logic              empty;
    } script_row_t;

    typedef enum {PH_FILL, PH_MIX_DOWN, PH_DRAIN, PH_MIX_UP} phase_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    logic [1:0]     kind = clqm_pkg::KIND_APPEND;
    clqm_pkg::idx_t entry_index = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic [1:0]     status;
    clqm_pkg::idx_t removed_entry;
    clqm_pkg::cnt_t entry_count;
    clqm_pkg::idx_t head_entry;
    logic           queue_empty;

    // Shadow copy of the queue
    clqm_pkg::idx_t link_next [clqm_pkg::POOL_ENTRIES];
    clqm_pkg::idx_t link_prev [clqm_pkg::POOL_ENTRIES];
    bit             linked    [clqm_pkg::POOL_ENTRIES];
    clqm_pkg::idx_t q_head  = '0;
    bit             q_empty = 1'b1;
    clqm_pkg::cnt_t q_count = '0;

    reply_t     replies_due [$];
    bit         tx_steady = 1'b0;
    bit         rx_steady = 1'b0;
    bit         long_hold = 1'b0;
    int         cycles = 0;
    int         errors = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         appends_ok = 0;
    int         removes_ok = 0;
    int         rejects = 0;
    int         full_hits = 0;

    script_row_t script [DIR_ROWS] = '{
        '{clqm_pkg::KIND_SIZE,   6'd0,  1'b1, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b1},
        '{clqm_pkg::KIND_REMOVE, 6'd0,  1'b1, clqm_pkg::ST_EMPTY,   6'd0, 7'd0, 6'd0,  1'b1},
        '{clqm_pkg::KIND_REMOVE, 6'd63, 1'b1, clqm_pkg::ST_EMPTY,   6'd0, 7'd0, 6'd0,  1'b1},
        '{KIND_SPARE,            6'd63, 1'b1, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b1},
        '{clqm_pkg::KIND_APPEND, 6'd63, 1'b1, clqm_pkg::ST_OK,      6'd0, 7'd1, 6'd63, 1'b0},
        '{clqm_pkg::KIND_APPEND, 6'd63, 1'b1, clqm_pkg::ST_LINKED,  6'd0, 7'd1, 6'd63, 1'b0},
        '{clqm_pkg::KIND_APPEND, 6'd0,  1'b1, clqm_pkg::ST_OK,      6'd0, 7'd2, 6'd63, 1'b0},
        '{clqm_pkg::KIND_APPEND, 6'd42, 1'b1, clqm_pkg::ST_OK,      6'd0, 7'd3, 6'd63, 1'b0},
        '{clqm_pkg::KIND_APPEND, 6'd21, 1'b1, clqm_pkg::ST_OK,      6'd0, 7'd4, 6'd63, 1'b0},
        '{clqm_pkg::KIND_REMOVE, 6'd5,  1'b1, clqm_pkg::ST_NOT_MEMBER,
                                                                    6'd0, 7'd4, 6'd63, 1'b0},
        '{clqm_pkg::KIND_REMOVE, 6'd42, 1'b0, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b0},
        '{clqm_pkg::KIND_REMOVE, 6'd63, 1'b0, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b0},
        '{clqm_pkg::KIND_SIZE,   6'd21, 1'b0, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b0},
        '{clqm_pkg::KIND_REMOVE, 6'd21, 1'b0, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b0},
        '{clqm_pkg::KIND_APPEND, 6'd21, 1'b0, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b0},
        '{clqm_pkg::KIND_REMOVE, 6'd0,  1'b0, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b0},
        '{clqm_pkg::KIND_REMOVE, 6'd21, 1'b0, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b0},
        '{clqm_pkg::KIND_REMOVE, 6'd21, 1'b1, clqm_pkg::ST_EMPTY,   6'd0, 7'd0, 6'd0,  1'b1},
        '{clqm_pkg::KIND_APPEND, 6'd1,  1'b1, clqm_pkg::ST_OK,      6'd0, 7'd1, 6'd1,  1'b0},
        '{clqm_pkg::KIND_REMOVE, 6'd1,  1'b1, clqm_pkg::ST_OK,      6'd1, 7'd0, 6'd0,  1'b1},
        '{clqm_pkg::KIND_APPEND, 6'd7,  1'b0, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b0},
        '{clqm_pkg::KIND_APPEND, 6'd7,  1'b1, clqm_pkg::ST_LINKED,  6'd0, 7'd1, 6'd7,  1'b0},
        '{KIND_SPARE,            6'd0,  1'b0, clqm_pkg::ST_OK,      6'd0, 7'd0, 6'd0,  1'b0}
    };

    circular_linked_queue_manager_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .entry_index   (entry_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .removed_entry (removed_entry),
        .entry_count   (entry_count),
        .head_entry    (head_entry),
        .queue_empty   (queue_empty)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("circular_linked_queue_manager_top_test: errors");
            $finish;
        end
    end

    // Apply one operation to the shadow queue and return the reply it should produce.
    function automatic reply_t track_queue(input logic [1:0] op, input clqm_pkg::idx_t e);
        reply_t         r;
        clqm_pkg::idx_t tail;
        clqm_pkg::idx_t n;
        clqm_pkg::idx_t p;
        r.st  = clqm_pkg::ST_OK;
        r.rem = '0;
        case (op)
            clqm_pkg::KIND_APPEND:
            begin
                if (linked[e])
                begin
                    r.st = clqm_pkg::ST_LINKED;
                    rejects++;
                end
                else
                begin
                    if (q_empty)
                    begin
                        link_next[e] = e;
                        link_prev[e] = e;
                        q_head  = e;
                        q_empty = 1'b0;
                        q_count = clqm_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        tail = link_prev[q_head];
                        link_next[tail]   = e;
                        link_next[e]      = q_head;
                        link_prev[e]      = tail;
                        link_prev[q_head] = e;
                        q_count++;
                    end
                    linked[e] = 1'b1;
                    appends_ok++;
                    if (q_count == clqm_pkg::POOL_LIMIT)
                        full_hits++;
                end
            end
            clqm_pkg::KIND_REMOVE:
            begin
                if (q_empty)
                begin
                    r.st = clqm_pkg::ST_EMPTY;
                    rejects++;
                end
                else if (!linked[e])
                begin
                    r.st = clqm_pkg::ST_NOT_MEMBER;
                    rejects++;
                end
                else
                begin
                    n = link_next[e];
                    p = link_prev[e];
                    link_prev[n] = p;
                    link_next[p] = n;
                    linked[e] = 1'b0;
                    if (q_count > 0)
                        q_count--;
                    if (n == e || q_count == 0)
                    begin
                        q_empty = 1'b1;
                        q_head  = '0;
                        q_count = '0;
                    end
                    else if (q_head == e)
                        q_head = n;
                    r.rem = e;
                    removes_ok++;
                end
            end
            default: ;
        endcase
        r.cnt   = q_count;
        r.head  = q_empty ? '0 : q_head;
        r.empty = q_empty;
        return r;
    endfunction

    task automatic offer(input logic [1:0] op, input clqm_pkg::idx_t ix,
                         output reply_t predicted);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= op;
        entry_index <= ix;
        do @(posedge clk); while (!in_ready);
        predicted = track_queue(op, ix);
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding reply is back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Reply side
    initial
    begin
        int     w;
        reply_t want;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                w = LONG_HOLD;
                long_hold = 1'b0;
            end
            else
                w = rx_steady ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, status %0d count %0d head %0d",
                         $time, status, entry_count, head_entry);
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("status", want.st, status);
                check_field("removed_entry", want.rem, removed_entry);
                check_field("entry_count", want.cnt, entry_count);
                check_field("head_entry", want.head, head_entry);
                check_field("queue_empty", want.empty, queue_empty);
            end
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
        end
    end

    // Request side
    initial
    begin
        reply_t         got;
        phase_t         phase;
        logic [1:0]     op;
        clqm_pkg::idx_t ix;
        int             roll;
        int             append_pct;
        int             left;
        int             phase_no;
        int             random_sent;
        phase       = PH_FILL;
        phase_no    = 0;
        left        = 300;
        random_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            offer(script[i].op, script[i].ix, got);
            if (script[i].typed)
                replies_due.push_back('{script[i].st, script[i].rem, script[i].cnt,
                                        script[i].head, script[i].empty});
            else
                replies_due.push_back(got);
        end
        drain();

        // Alternate fill, mixed, drain and mixed phases; keep a tenth as noise.
        while (random_sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            append_pct = (phase == PH_FILL) ? 80 : (phase == PH_DRAIN) ? 10 : 45;
            if (roll >= 90)
            begin
                op = 2'($urandom_range(0, 3));
                ix = clqm_pkg::idx_t'($urandom_range(0, clqm_pkg::POOL_ENTRIES - 1));
            end
            else if (roll < append_pct)
            begin
                op = clqm_pkg::KIND_APPEND;
                do ix = clqm_pkg::idx_t'($urandom_range(0, clqm_pkg::POOL_ENTRIES - 1));
                while (linked[ix] && q_count != clqm_pkg::POOL_LIMIT);
            end
            else
            begin
                op = clqm_pkg::KIND_REMOVE;
                do ix = clqm_pkg::idx_t'($urandom_range(0, clqm_pkg::POOL_ENTRIES - 1));
                while (!linked[ix] && !q_empty);
            end
            offer(op, ix, got);
            replies_due.push_back(got);
            random_sent++;
            if (random_sent == 400)
                long_hold = 1'b1;
            left--;
            if ((phase == PH_FILL && q_count == clqm_pkg::POOL_LIMIT) ||
                (phase == PH_DRAIN && q_empty) || left <= 0)
            begin
                phase_no++;
                phase = phase_t'(phase_no % 4);
                left  = (phase == PH_FILL || phase == PH_DRAIN) ? 300 : $urandom_range(20, 100);
                tx_steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0)
                    drain();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d requests (%0d scripted), checked %0d replies:",
                 items_sent, DIR_ROWS, results_seen);
        $display("%0d appends, %0d removes, %0d rejected; queue filled to all %0d entries %0d times.",
                 appends_ok, removes_ok, rejects, clqm_pkg::POOL_ENTRIES, full_hits);
        if (errors == 0)
            $display("circular_linked_queue_manager_top_test: clean");
        else
            $display("circular_linked_queue_manager_top_test: errors");
        $finish;
    end

endmodule
